FILE: rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants
// Word formats, command and register codes, and the saturation helper used
// by the shift and rotation stages of the decenter coordinate transform.
// ----------------------------------------------------------------------------
package dct_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned Q_FRAC  = 30;

	// commands
	localparam logic [1:0] CMD_FWD_POINT = 2'd0;
	localparam logic [1:0] CMD_REV_POINT = 2'd1;
	localparam logic [1:0] CMD_FWD_DIR   = 2'd2;
	localparam logic [1:0] CMD_REV_DIR   = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_SHIFT_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROT_X   = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROT_Y   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROT_Z   = 3'd5;

	// cos 1.0, sin 0.0
	localparam logic [CFG_W-1:0] ROT_RESET = 64'h4000_0000_0000_0000;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               overflow;
	} out_word_t;

	// one item in flight between stages
	typedef struct packed {
		logic               vld;
		logic [1:0]         cmd;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               ovf;
	} pipe_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	function automatic logic is_rev(input logic [1:0] cmd);
		return (cmd == CMD_REV_POINT) || (cmd == CMD_REV_DIR);
	endfunction

	// clamp a 35-bit signed value to 32 bits
	function automatic sat_t sat32(input logic signed [34:0] v);
		sat_t r;
		if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end else begin
			r.ovf = 1'b1;
			r.val = v[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

FILE: rtl/dct_shift.sv
// ----------------------------------------------------------------------------
// dct_shift: shift stage
// Subtracts (pre) or adds (post) the shift vector for point commands, with
// saturation; one register stage.
// ----------------------------------------------------------------------------
module dct_shift
	import dct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               post,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  pipe_t              d,
	output pipe_t              q
);

	logic  active;
	sat_t  sx, sy, sz;
	pipe_t nxt;

	always_comb begin
		active = post ? (d.cmd == CMD_REV_POINT) : (d.cmd == CMD_FWD_POINT);
		if (post) begin
			sx = sat32(35'(d.x) + 35'(shift_x));
			sy = sat32(35'(d.y) + 35'(shift_y));
			sz = sat32(35'(d.z) + 35'(shift_z));
		end else begin
			sx = sat32(35'(d.x) - 35'(shift_x));
			sy = sat32(35'(d.y) - 35'(shift_y));
			sz = sat32(35'(d.z) - 35'(shift_z));
		end
		nxt = d;
		if (active) begin
			nxt.x   = sx.val;
			nxt.y   = sy.val;
			nxt.z   = sz.val;
			nxt.ovf = d.ovf | sx.ovf | sy.ovf | sz.ovf;
		end
	end

	pipe_t stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (en) begin
			stage_s1 <= nxt;
		end
	end

	assign q = stage_s1;

endmodule

FILE: rtl/dct_rot.sv
// ----------------------------------------------------------------------------
// dct_rot: rotation step
// Rotates one coordinate pair about a single axis: four 32x32 products in
// the first stage, sum, round to nearest and saturate in the second.
// ----------------------------------------------------------------------------
module dct_rot
	import dct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  axis_t       axis_fwd,
	input  axis_t       axis_rev,
	input  logic [63:0] cs_fwd,
	input  logic [63:0] cs_rev,
	input  pipe_t       d,
	output pipe_t       q
);

	localparam logic signed [64:0] RND = 65'sd1 <<< (Q_FRAC - 1);

	logic               rev;
	axis_t              axis;
	logic [63:0]        cs;
	logic signed [31:0] c, s, a, b;

	always_comb begin
		rev  = is_rev(d.cmd);
		axis = rev ? axis_rev : axis_fwd;
		cs   = rev ? cs_rev : cs_fwd;
		c    = cs[63:32];
		s    = cs[31:0];
		case (axis)
			AXIS_X: begin
				a = d.y;
				b = d.z;
			end
			AXIS_Y: begin
				a = d.z;
				b = d.x;
			end
			AXIS_Z: begin
				a = d.x;
				b = d.y;
			end
			default: begin
				a = d.x;
				b = d.y;
			end
		endcase
	end

	// product stage
	logic signed [63:0] ca_s1, sb_s1, cb_s1, sa_s1;
	pipe_t              pipe_s1;
	axis_t              axis_s1;
	logic               rev_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
			axis_s1 <= AXIS_X;
			rev_s1  <= 1'b0;
			ca_s1   <= '0;
			sb_s1   <= '0;
			cb_s1   <= '0;
			sa_s1   <= '0;
		end else if (en) begin
			pipe_s1 <= d;
			axis_s1 <= axis;
			rev_s1  <= rev;
			ca_s1   <= 64'(c) * 64'(a);
			sb_s1   <= 64'(s) * 64'(b);
			cb_s1   <= 64'(c) * 64'(b);
			sa_s1   <= 64'(s) * 64'(a);
		end
	end

	// sum, round, saturate
	logic signed [64:0] sum_a, sum_b, rnd_a, rnd_b;
	sat_t               na, nb;
	pipe_t              nxt;

	always_comb begin
		if (rev_s1) begin
			sum_a = 65'(ca_s1) - 65'(sb_s1);
			sum_b = 65'(cb_s1) + 65'(sa_s1);
		end else begin
			sum_a = 65'(ca_s1) + 65'(sb_s1);
			sum_b = 65'(cb_s1) - 65'(sa_s1);
		end
		rnd_a = sum_a + RND;
		rnd_b = sum_b + RND;
		na    = sat32(rnd_a[64:Q_FRAC]);
		nb    = sat32(rnd_b[64:Q_FRAC]);
		nxt   = pipe_s1;
		nxt.ovf = pipe_s1.ovf | na.ovf | nb.ovf;
		case (axis_s1)
			AXIS_X: begin
				nxt.y = na.val;
				nxt.z = nb.val;
			end
			AXIS_Y: begin
				nxt.z = na.val;
				nxt.x = nb.val;
			end
			AXIS_Z: begin
				nxt.x = na.val;
				nxt.y = nb.val;
			end
			default: begin
				nxt.x = na.val;
				nxt.y = nb.val;
			end
		endcase
	end

	pipe_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (en) begin
			res_s2 <= nxt;
		end
	end

	assign q = res_s2;

endmodule

FILE: rtl/decenter_coordinate_transform_unit.sv
// ----------------------------------------------------------------------------
// decenter_coordinate_transform_unit: decentered-frame rigid transform
// Moves Q16.16 points and directions between an undecentered and a
// decentered frame using a shift vector and three axis rotations.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while in_stall is low and returns one
// result word per input, in order, from the output register. The pipeline
// is made of these stages: shift subtract (forward point only), three
// rotation steps of two stages each (products, then sum/round/saturate),
// and shift add (reverse point only); the last stage is the output register.
// The whole pipeline advances together; out_stall holds every stage while a
// result is waiting, and in_stall follows it. Forward commands rotate about
// X, then Y, then Z; reverse commands rotate about Z, Y, X with the sine
// negated. Rotation coefficients are signed Q2.30 cosine (upper half) and
// sine (lower half) per axis, used as given. Each product pair is rounded
// to nearest with ties toward plus infinity, and every shift and rotation
// result clamps to 32 bits; overflow reports any clamp along the way.
// Write configuration only while no word is in flight; writes to indexes
// above five are dropped.
// ----------------------------------------------------------------------------
module decenter_coordinate_transform_unit
	import dct_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_word_t                 in_word,

	output logic                     out_valid,
	input  logic                     out_stall,
	output out_word_t                out_word,

	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	// configuration registers
	logic signed [31:0] shift_x_q, shift_y_q, shift_z_q;
	logic [63:0]        rot_x_q, rot_y_q, rot_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
			rot_x_q   <= ROT_RESET;
			rot_y_q   <= ROT_RESET;
			rot_z_q   <= ROT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHIFT_X: shift_x_q <= cfg_data[31:0];
				REG_SHIFT_Y: shift_y_q <= cfg_data[31:0];
				REG_SHIFT_Z: shift_z_q <= cfg_data[31:0];
				REG_ROT_X:   rot_x_q   <= cfg_data;
				REG_ROT_Y:   rot_y_q   <= cfg_data;
				REG_ROT_Z:   rot_z_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: hold everything while a finished word waits
	pipe_t in_p, pre_s1, rot1_s3, rot2_s5, rot3_s7, post_s8;
	logic  en;

	assign en       = !(post_s8.vld && out_stall);
	assign in_stall = !en;

	always_comb begin
		in_p.vld = in_valid;
		in_p.cmd = in_word.cmd;
		in_p.x   = in_word.in_x;
		in_p.y   = in_word.in_y;
		in_p.z   = in_word.in_z;
		in_p.ovf = 1'b0;
	end

	dct_shift u_pre (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.post    (1'b0),
		.shift_x (shift_x_q),
		.shift_y (shift_y_q),
		.shift_z (shift_z_q),
		.d       (in_p),
		.q       (pre_s1)
	);

	// first step: X forward, Z reverse
	dct_rot u_rot1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.axis_fwd (AXIS_X),
		.axis_rev (AXIS_Z),
		.cs_fwd   (rot_x_q),
		.cs_rev   (rot_z_q),
		.d        (pre_s1),
		.q        (rot1_s3)
	);

	dct_rot u_rot2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.axis_fwd (AXIS_Y),
		.axis_rev (AXIS_Y),
		.cs_fwd   (rot_y_q),
		.cs_rev   (rot_y_q),
		.d        (rot1_s3),
		.q        (rot2_s5)
	);

	// last step: Z forward, X reverse
	dct_rot u_rot3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.axis_fwd (AXIS_Z),
		.axis_rev (AXIS_X),
		.cs_fwd   (rot_z_q),
		.cs_rev   (rot_x_q),
		.d        (rot2_s5),
		.q        (rot3_s7)
	);

	dct_shift u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.post    (1'b1),
		.shift_x (shift_x_q),
		.shift_y (shift_y_q),
		.shift_z (shift_z_q),
		.d       (rot3_s7),
		.q       (post_s8)
	);

	assign out_valid         = post_s8.vld;
	assign out_word.out_x    = post_s8.x;
	assign out_word.out_y    = post_s8.y;
	assign out_word.out_z    = post_s8.z;
	assign out_word.overflow = post_s8.ovf;

endmodule
